/* src/v4n_pkg.sv */
`timescale 1ns / 1ps
package v4n_pkg;

  typedef enum logic [1:0] {
    CMD_LENGTH    = 2'd0,
    CMD_NORMALIZE = 2'd1,
    CMD_DISTANCE  = 2'd2,
    CMD_COMPARE   = 2'd3
  } cmd_e;

  localparam int unsigned Lanes    = 4;
  localparam int unsigned SqrtBits = 32;   // root bits, one per pipeline stage
  localparam int unsigned QuoBits  = 49;   // (m << 16) / r needs up to 49 bits
  localparam logic [30:0] LenMax   = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  neg;
    logic [3:0]  in_tol;
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] a_z;
    logic [31:0] a_w;
  } side_t;

  typedef struct packed {
    logic [30:0] length;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    logic [31:0] norm_w;
    logic        match;
  } res_t;

endpackage

/* src/v4n_if.sv */
`timescale 1ns / 1ps
interface v4n_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] a_x;
  logic [31:0] a_y;
  logic [31:0] a_z;
  logic [31:0] a_w;
  logic [31:0] b_x;
  logic [31:0] b_y;
  logic [31:0] b_z;
  logic [31:0] b_w;
  logic [30:0] tolerance;
  modport source (output valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, tolerance,
                  input ready);
  modport sink (input valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, tolerance,
                output ready);
endinterface

interface v4n_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] length;
  logic [31:0] norm_x;
  logic [31:0] norm_y;
  logic [31:0] norm_z;
  logic [31:0] norm_w;
  logic        match;
  modport source (output valid, length, norm_x, norm_y, norm_z, norm_w, match,
                  input ready);
  modport sink (input valid, length, norm_x, norm_y, norm_z, norm_w, match,
                output ready);
endinterface

/* src/v4n_lane.sv */
`timescale 1ns / 1ps
// One component lane: magnitude of the selected operand and its square.
module v4n_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic        diff_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [30:0] tol_i,
  output logic [32:0] mag_o,
  output logic        neg_o,
  output logic        within_o,
  output logic [63:0] sq_o
);
  logic signed [32:0] d;
  logic [32:0]        m;
  logic [32:0]        mag_q;
  logic [63:0]        sq_q;

  always_comb begin
    d = $signed({a_i[31], a_i}) - (diff_i ? $signed({b_i[31], b_i}) : 33'sd0);
    m = d[32] ? 33'(-d) : 33'(d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q    <= m;
      neg_o    <= a_i[31];
      within_o <= (m <= {2'b00, tol_i});
      sq_q     <= m[32] ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(m[31:0] * m[31:0]);
    end
  end

  assign mag_o = mag_q;
  assign sq_o  = sq_q;
endmodule

/* src/v4n_sqrt.sv */
`timescale 1ns / 1ps
// Saturating sum of four squares, then a restoring square root one bit per stage.
module v4n_sqrt (
  input  logic         clk_i,
  input  logic [31:0]  en_i,
  input  logic         sum_en_i,
  input  logic [255:0] sq_i,
  output logic [31:0]  root_o
);
  logic [63:0] s01, s23, s_all;
  logic        c01, c23, call;
  logic [63:0] sum_q;
  logic [63:0] rem_q  [v4n_pkg::SqrtBits+1];
  logic [31:0] root_q [v4n_pkg::SqrtBits+1];

  always_comb begin
    {c01, s01} = 65'(sq_i[63:0]) + 65'(sq_i[127:64]);
    {c23, s23} = 65'(sq_i[191:128]) + 65'(sq_i[255:192]);
    {call, s_all} = 65'(s01) + 65'(s23);
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      sum_q <= (c01 | c23 | call) ? 64'hFFFF_FFFF_FFFF_FFFF : s_all;
    end
  end

  assign rem_q[0]  = sum_q;
  assign root_q[0] = '0;

  for (genvar k = 0; k < v4n_pkg::SqrtBits; k++) begin : g_step
    localparam int unsigned B = v4n_pkg::SqrtBits - 1 - k;
    logic [65:0] trial;
    always_comb trial = {2'b00, root_q[k], 32'd0} >> (32 - B - 1)
                        | (66'd1 << (2 * B));
    // trial = (root << (B+1)) + 4^B with root holding the upper bits found so far
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        if ({2'b00, rem_q[k]} >= trial) begin
          rem_q[k+1]  <= 64'({2'b00, rem_q[k]} - trial);
          root_q[k+1] <= root_q[k] | (32'd1 << B);
        end else begin
          rem_q[k+1]  <= rem_q[k];
          root_q[k+1] <= root_q[k];
        end
      end
    end
  end

  assign root_o = root_q[v4n_pkg::SqrtBits];
endmodule

/* src/v4n_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: (mag << 16) / root, one quotient bit per stage.
module v4n_div (
  input  logic        clk_i,
  input  logic [48:0] en_i,
  input  logic [32:0] mag_i,
  input  logic [31:0] den_i,
  output logic [48:0] quo_o
);
  localparam int unsigned N = v4n_pkg::QuoBits;
  logic [48:0] num_q [N+1];
  logic [32:0] rem_q [N+1];
  logic [31:0] den_q [N+1];

  assign num_q[0] = {mag_i, 16'd0};
  assign rem_q[0] = '0;
  assign den_q[0] = den_i;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [33:0] sh;
    always_comb sh = {rem_q[k], num_q[k][N-1]};
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        den_q[k+1] <= den_q[k];
        if (sh >= {2'b00, den_q[k]}) begin
          rem_q[k+1] <= 33'(sh - {2'b00, den_q[k]});
          num_q[k+1] <= {num_q[k][N-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= sh[32:0];
          num_q[k+1] <= {num_q[k][N-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = num_q[N];
endmodule

/* src/vec4_length_normalize_compare_core.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_req    in   cmd, a_x..a_w, b_x..b_w, tolerance
// out_req   out  length, norm_x..norm_w, match
//
// One request enters per cycle while in_req.ready is high; each result is formed by
// the 32-stage root pipeline followed by the 49-stage quotient pipeline.
// rst_ni clears only the stage valid bits. A stalled output holds the full
// stages in place; the input stays ready while any stage holds a hole or
// the last stage is being taken, so bubbles close up even under backpressure.
module vec4_length_normalize_compare_core (
  input  logic clk_i,
  input  logic rst_ni,
  v4n_in_if.sink    in_req,
  v4n_out_if.source out_req
);
  // Stages: 1 lane, 1 sum, 32 root, 1 root hold, 49 divide = 84.
  localparam int unsigned Depth = 2 + v4n_pkg::SqrtBits + 1 + v4n_pkg::QuoBits;
  // Stage that holds the finished root, which feeds the dividers.
  localparam int unsigned RS = 2 + v4n_pkg::SqrtBits;

  logic [Depth-1:0] vld_q;
  logic [Depth-1:0] en;

  // A stage advances when it, or any stage after it, can move into a hole.
  always_comb begin
    en[Depth-1] = !vld_q[Depth-1] || out_req.ready;
    for (int i = Depth - 2; i >= 0; i--) begin
      en[i] = en[i+1] || !vld_q[i];
    end
  end

  assign in_req.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_req.valid;
      for (int i = 1; i < Depth; i++) begin
        if (en[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Lanes.
  logic         diff;
  logic [32:0]  mag [v4n_pkg::Lanes];
  logic [3:0]   neg, in_tol;
  logic [255:0] sq;
  logic [31:0]  av [v4n_pkg::Lanes];
  logic [31:0]  bv [v4n_pkg::Lanes];
  assign diff = (in_req.cmd == v4n_pkg::CMD_DISTANCE) || (in_req.cmd == v4n_pkg::CMD_COMPARE);
  assign av = '{in_req.a_x, in_req.a_y, in_req.a_z, in_req.a_w};
  assign bv = '{in_req.b_x, in_req.b_y, in_req.b_z, in_req.b_w};

  for (genvar l = 0; l < v4n_pkg::Lanes; l++) begin : g_lane
    v4n_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en[0]),
      .diff_i   (diff),
      .a_i      (av[l]),
      .b_i      (bv[l]),
      .tol_i    (in_req.tolerance),
      .mag_o    (mag[l]),
      .neg_o    (neg[l]),
      .within_o (in_tol[l]),
      .sq_o     (sq[64*l +: 64])
    );
  end

  // Side information rides along with each request. The lane flags join it
  // on the way into stage 1. Entry j of magd_q holds the magnitudes of
  // stage j + 1, so the last entry lines up with the root hold stage.
  v4n_pkg::side_t side_q [Depth];
  v4n_pkg::side_t side_in;
  logic [32:0]    magd_q [v4n_pkg::Lanes][RS];

  always_comb begin
    side_in        = side_q[0];
    side_in.neg    = neg;
    side_in.in_tol = in_tol;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= '{cmd: in_req.cmd, neg: 4'd0, in_tol: 4'd0, a_x: in_req.a_x,
                     a_y: in_req.a_y, a_z: in_req.a_z, a_w: in_req.a_w};
    end
    if (en[1]) begin
      side_q[1] <= side_in;
      for (int l = 0; l < v4n_pkg::Lanes; l++) begin
        magd_q[l][0] <= mag[l];
      end
    end
    for (int i = 2; i < Depth; i++) begin
      if (en[i]) side_q[i] <= side_q[i-1];
    end
    for (int i = 2; i <= RS; i++) begin
      if (en[i]) begin
        for (int l = 0; l < v4n_pkg::Lanes; l++) begin
          magd_q[l][i-1] <= magd_q[l][i-2];
        end
      end
    end
  end

  // Merge: saturated sum and root over the lanes.
  logic [31:0] root;
  v4n_sqrt u_sqrt (
    .clk_i    (clk_i),
    .en_i     (en[2 +: v4n_pkg::SqrtBits]),
    .sum_en_i (en[1]),
    .sq_i     (sq),
    .root_o   (root)
  );

  // Root stage register: length and divisor.
  logic [31:0] root_q;
  always_ff @(posedge clk_i) begin
    if (en[RS]) root_q <= root;
  end

  // The root travels beside the quotient; entry j holds stage RS + 1 + j.
  logic [31:0] root_dly_q [v4n_pkg::QuoBits];
  always_ff @(posedge clk_i) begin
    if (en[RS + 1]) root_dly_q[0] <= root_q;
    for (int i = 1; i < v4n_pkg::QuoBits; i++) begin
      if (en[RS + 1 + i]) root_dly_q[i] <= root_dly_q[i-1];
    end
  end

  logic [48:0] quo [v4n_pkg::Lanes];
  for (genvar l = 0; l < v4n_pkg::Lanes; l++) begin : g_div
    v4n_div u_div (
      .clk_i (clk_i),
      .en_i  (en[RS + 1 +: v4n_pkg::QuoBits]),
      .mag_i (magd_q[l][RS-1]),
      .den_i ((root_q == '0) ? 32'd1 : root_q),
      .quo_o (quo[l])
    );
  end

  // Output assembly from the last stage.
  v4n_pkg::side_t so;
  logic [31:0]    r_out;
  logic [31:0]    nrm [v4n_pkg::Lanes];
  logic [31:0]    a_o [v4n_pkg::Lanes];
  v4n_pkg::res_t  res;
  assign so    = side_q[Depth-1];
  assign r_out = root_dly_q[v4n_pkg::QuoBits-1];
  assign a_o   = '{so.a_x, so.a_y, so.a_z, so.a_w};
  always_comb begin
    res = '0;
    for (int l = 0; l < v4n_pkg::Lanes; l++) nrm[l] = '0;
    unique case (v4n_pkg::cmd_e'(so.cmd))
      v4n_pkg::CMD_LENGTH, v4n_pkg::CMD_DISTANCE: begin
        res.length = r_out[31] ? v4n_pkg::LenMax : r_out[30:0];
      end
      v4n_pkg::CMD_NORMALIZE: begin
        res.length = r_out[31] ? v4n_pkg::LenMax : r_out[30:0];
        for (int l = 0; l < v4n_pkg::Lanes; l++) begin
          if (r_out == '0) nrm[l] = a_o[l];
          else nrm[l] = so.neg[l] ? 32'(-quo[l]) : quo[l][31:0];
        end
      end
      v4n_pkg::CMD_COMPARE: res.match = &so.in_tol;
      default: res = '0;
    endcase
    res.norm_x = nrm[0];
    res.norm_y = nrm[1];
    res.norm_z = nrm[2];
    res.norm_w = nrm[3];
  end

  assign out_req.valid  = vld_q[Depth-1];
  assign out_req.length = res.length;
  assign out_req.norm_x = res.norm_x;
  assign out_req.norm_y = res.norm_y;
  assign out_req.norm_z = res.norm_z;
  assign out_req.norm_w = res.norm_w;
  assign out_req.match  = res.match;
endmodule

/* sim/vec4_check.sv */
`timescale 1ns / 1ps
// Watches both channels, computes the expected vector result for every
// accepted request and compares each delivered result against it.
module vec4_check (
  input  logic clk_i,
  input  logic rst_ni,
  v4n_in_if.sink    in_mon,
  v4n_out_if.sink   out_mon,
  output int        fail_count_o,
  output int        pending_o
);

  v4n_pkg::res_t expected_q[$];

  function automatic logic [63:0] sat_sq(logic [32:0] m);
    if (m[32]) return '1;
    return 64'(m) * 64'(m);
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] x, logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Floor square root, one result bit at a time from the top.
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = 128'(r | (64'd1 << b));
      if (t * t <= 128'(v)) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  function automatic logic [30:0] clamp_len(logic [63:0] r);
    return (r > 64'(v4n_pkg::LenMax)) ? v4n_pkg::LenMax : r[30:0];
  endfunction

  function automatic v4n_pkg::res_t vec_result(logic [1:0] cmd, logic [31:0] a [4],
                                               logic [31:0] b [4], logic [30:0] tol);
    v4n_pkg::res_t res;
    logic signed [33:0] d;
    logic [32:0] m [4];
    logic [63:0] sum, r, q;
    logic [31:0] nrm [4];
    res = '0;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      if (cmd == v4n_pkg::CMD_DISTANCE || cmd == v4n_pkg::CMD_COMPARE)
        d = 34'($signed(a[i])) - 34'($signed(b[i]));
      else
        d = 34'($signed(a[i]));
      m[i] = d[33] ? 33'(-d) : d[32:0];
      sum = sat_sum(sum, sat_sq(m[i]));
      nrm[i] = '0;
    end
    r = floor_root(sum);
    case (cmd)
      v4n_pkg::CMD_LENGTH, v4n_pkg::CMD_DISTANCE: res.length = clamp_len(r);
      v4n_pkg::CMD_NORMALIZE: begin
        res.length = clamp_len(r);
        for (int i = 0; i < 4; i++) begin
          if (r == 0) nrm[i] = a[i];
          else begin
            q = (64'(m[i]) << 16) / r;
            nrm[i] = a[i][31] ? 32'(-q) : q[31:0];
          end
        end
      end
      default: begin
        res.match = 1'b1;
        for (int i = 0; i < 4; i++)
          if (m[i] > 33'(tol)) res.match = 1'b0;
      end
    endcase
    {res.norm_x, res.norm_y, res.norm_z, res.norm_w} = {nrm[0], nrm[1], nrm[2], nrm[3]};
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    logic [31:0] a [4];
    logic [31:0] b [4];
    v4n_pkg::res_t want;
    if (rst_ni && in_mon.valid && in_mon.ready) begin
      a = '{in_mon.a_x, in_mon.a_y, in_mon.a_z, in_mon.a_w};
      b = '{in_mon.b_x, in_mon.b_y, in_mon.b_z, in_mon.b_w};
      expected_q.push_back(vec_result(in_mon.cmd, a, b, in_mon.tolerance));
    end
    if (rst_ni && out_mon.valid && out_mon.ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected result, length", 32'(out_mon.length), 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_mon.length !== want.length)
          report("length", 32'(out_mon.length), 32'(want.length));
        if (out_mon.norm_x !== want.norm_x) report("norm_x", out_mon.norm_x, want.norm_x);
        if (out_mon.norm_y !== want.norm_y) report("norm_y", out_mon.norm_y, want.norm_y);
        if (out_mon.norm_z !== want.norm_z) report("norm_z", out_mon.norm_z, want.norm_z);
        if (out_mon.norm_w !== want.norm_w) report("norm_w", out_mon.norm_w, want.norm_w);
        if (out_mon.match !== want.match)
          report("match", 32'(out_mon.match), 32'(want.match));
      end
    end
    pending_o = expected_q.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Top of the vector unit bench. It drives directed requests, then random ones in bursts,
// stalls the result side on its own pattern, and leaves all checking to vec4_check.
module tb;

  localparam int RandomCount = 1500;
  localparam int Latency     = 84;
  localparam int CycleLimit  = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   hold_off = 0;     // cycles left in a long receiver stall

  v4n_in_if  in_req ();
  v4n_out_if out_req ();

  vec4_length_normalize_compare_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_req (in_req.sink),
    .out_req(out_req.source)
  );

  vec4_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_req.sink),
    .out_mon     (out_req.sink),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #6 clk_i = ~clk_i;

  // The run is cut off if it ever takes far longer than any correct run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // A component value drawn often from the edges of the Q16.16 range, so
  // that saturation and sign handling come up often.
  function automatic logic [31:0] pick_comp();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 131072)) - 65536);
      3: return 32'h0;
      4: return 32'($urandom_range(0, 255)) << $urandom_range(0, 24);
      default: return $urandom();
    endcase
  endfunction

  // Receiver: its own random stall pattern, with quiet stretches, and the
  // long hold-offs counted down here.
  initial begin
    out_req.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_req.ready <= 1'b0;
      end else if ((cycle_count / 500) % 3 == 0) begin
        out_req.ready <= 1'b1;
      end else begin
        out_req.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Drives one request and waits until the block takes it.
  task automatic send_req(logic [1:0] cmd, logic [31:0] a [4], logic [31:0] b [4],
                          logic [30:0] tol);
    in_req.valid     <= 1'b1;
    in_req.cmd       <= cmd;
    in_req.a_x       <= a[0];
    in_req.a_y       <= a[1];
    in_req.a_z       <= a[2];
    in_req.a_w       <= a[3];
    in_req.b_x       <= b[0];
    in_req.b_y       <= b[1];
    in_req.b_z       <= b[2];
    in_req.b_w       <= b[3];
    in_req.tolerance <= tol;
    do @(posedge clk_i); while (!in_req.ready);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_req.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [31:0] a [4];
    logic [31:0] b [4];
    logic [30:0] tol;
    logic [1:0]  cmd;
    int burst;
    int settle;
    bit held;

    held = 1'b0;
    in_req.valid = 1'b0;
    in_req.cmd = v4n_pkg::CMD_LENGTH;
    {in_req.a_x, in_req.a_y, in_req.a_z, in_req.a_w} = '0;
    {in_req.b_x, in_req.b_y, in_req.b_z, in_req.b_w} = '0;
    in_req.tolerance = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests: zero vectors, unit vector, all-negative extremes
    // that saturate the sum, the largest positive values, and compares
    // right at, just past and far beyond the tolerance.
    b = '{default: 32'h0};
    a = '{default: 32'h0};
    send_req(v4n_pkg::CMD_LENGTH, a, b, '0);
    send_req(v4n_pkg::CMD_NORMALIZE, a, b, '0);
    send_req(v4n_pkg::CMD_DISTANCE, a, b, '0);
    send_req(v4n_pkg::CMD_COMPARE, a, b, '0);
    a = '{32'h0001_0000, 32'h0, 32'h0, 32'h0};
    send_req(v4n_pkg::CMD_NORMALIZE, a, b, '0);
    a = '{default: 32'h8000_0000};
    send_req(v4n_pkg::CMD_LENGTH, a, b, '0);
    send_req(v4n_pkg::CMD_NORMALIZE, a, b, '0);
    b = '{default: 32'h7FFF_FFFF};
    send_req(v4n_pkg::CMD_DISTANCE, a, b, '0);
    send_req(v4n_pkg::CMD_COMPARE, a, b, 31'h7FFF_FFFF);
    a = '{default: 32'h7FFF_FFFF};
    send_req(v4n_pkg::CMD_LENGTH, a, b, '0);
    send_req(v4n_pkg::CMD_NORMALIZE, a, b, '0);
    a = '{32'h0000_0005, 32'hFFFF_FFFB, 32'h0, 32'h1};
    b = '{32'h0, 32'h0, 32'h0, 32'h0};
    send_req(v4n_pkg::CMD_COMPARE, a, b, 31'd5);
    send_req(v4n_pkg::CMD_COMPARE, a, b, 31'd4);
    a = '{32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0};
    send_req(v4n_pkg::CMD_NORMALIZE, a, b, '0);
    b = '{32'h0000_0001, 32'h0, 32'h0, 32'h0};
    a = '{32'h8000_0000, 32'h0, 32'h0, 32'h0};
    send_req(v4n_pkg::CMD_DISTANCE, a, b, '0);
    send_req(v4n_pkg::CMD_NORMALIZE, a, b, '0);

    // Random requests in bursts. Early on the receiver is held off for a
    // long stretch so the pipeline fills and the input stalls.
    for (int n = 0; n < RandomCount; ) begin
      burst = $urandom_range(1, 40);
      if (n >= 200 && !held) begin
        hold_off = 300;
        held = 1'b1;
      end
      for (int k = 0; k < burst && n < RandomCount; k++, n++) begin
        cmd = 2'($urandom_range(0, 3));
        for (int i = 0; i < 4; i++) begin
          a[i] = pick_comp();
          // Compare and distance often use nearby vectors.
          b[i] = $urandom_range(0, 1) ? a[i] + 32'($signed($urandom_range(0, 64)) - 32)
                                      : pick_comp();
        end
        tol = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 40));
        send_req(cmd, a, b, tol);
      end
      idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 20));
    end
    in_req.valid <= 1'b0;

    wait (pending == 0);
    settle = 0;
    while (settle < 2 * Latency) begin
      @(posedge clk_i);
      settle++;
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
src/v4n_pkg.sv
src/v4n_if.sv
src/v4n_lane.sv
src/v4n_sqrt.sv
src/v4n_div.sv
src/vec4_length_normalize_compare_core.sv
sim/vec4_check.sv
sim/tb.sv
